// ===== rtl/smq_pkg.sv =====
`timescale 1ns / 1ps

package smq_pkg;

  // Store size and field widths
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 5;

  // Operation codes carried in func
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    val_t value;
  } cmd_t;

  // What a cell hands to the cell below it
  typedef struct packed {
    val_t val;
    logic gt;
  } link_t;

endpackage

// ===== rtl/smq_in_if.sv =====
`timescale 1ns / 1ps

interface smq_in_if;
  import smq_pkg::*;

  logic valid;
  logic ready;
  logic func;
  val_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== rtl/smq_out_if.sv =====
`timescale 1ns / 1ps

interface smq_out_if;
  import smq_pkg::*;

  logic               valid;
  logic               ready;
  val_t               top_value;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic               error;

  modport source (output valid, output top_value, output count, output is_empty,
                  output error, input ready);
  modport sink   (input valid, input top_value, input count, input is_empty,
                  input error, output ready);
endinterface

// ===== rtl/sorted_min_stack_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                            Handshake
// in_i      in   func, value                        valid/ready
// out_o     out  top_value, count, is_empty, error  valid/ready
//
// One transaction a cycle: every input transaction yields one result in the
// cycle after it, and a new transaction is taken in that same cycle when the
// result register is free or being drained. The cell row updates all entries
// at once. Reset clears the entry count and the result valid; cell contents
// need none. A stalled result holds the input: ready drops only while out_o is
// full and not taken.

module sorted_min_stack_top import smq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  smq_in_if.sink    in_i,
  smq_out_if.source out_o
);

  // Handshake and operation decode
  logic fire, full, empty, do_push, do_pop, err;
  cnt_t count_q, count_d;
  logic out_valid_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign full       = (count_q == cnt_t'(DEPTH));
  assign empty      = (count_q == '0);
  assign do_push    = fire && (in_i.func == FUNC_PUSH) && !full;
  assign do_pop     = fire && (in_i.func == FUNC_POP) && !empty;
  // Drop push on full and pop on empty, and flag them
  assign err        = fire && !do_push && !do_pop;

  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + cnt_t'(1);
    end else if (do_pop) begin
      count_d = count_q - cnt_t'(1);
    end
  end

  // Cell row: cell 0 holds the minimum, larger values sit further down
  cmd_t  cmd;
  logic  occ  [DEPTH];
  link_t link [DEPTH];
  val_t  val_d [DEPTH];

  assign cmd = '{push: do_push, pop: do_pop, value: in_i.value};

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    link_t prev;
    val_t  next_val;

    assign occ[k] = (cnt_t'(k) < count_q);

    if (k == 0) begin : g_first
      assign prev = '{val: '0, gt: 1'b0};
    end else begin : g_mid
      assign prev = link[k-1];
    end

    // Last cell keeps its own value on pop; it leaves the occupied range anyway
    if (k == DEPTH - 1) begin : g_last
      assign next_val = link[k].val;
    end else begin : g_inner
      assign next_val = link[k+1].val;
    end

    smq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occ_i      (occ[k]),
      .prev_i     (prev),
      .next_val_i (next_val),
      .link_o     (link[k]),
      .val_d_o    (val_d[k])
    );
  end

  // Result register
  val_t               top_q;
  logic [COUNT_W-1:0] cnt_out_q;
  logic               empty_q, err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      top_q     <= (count_d == '0) ? '0 : val_d[0];
      cnt_out_q <= COUNT_W'(count_d);
      empty_q   <= (count_d == '0);
      err_q     <= err;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.top_value = top_q;
  assign out_o.count     = cnt_out_q;
  assign out_o.is_empty  = empty_q;
  assign out_o.error     = err_q;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(DEPTH))
    else $error("entry count above depth");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (empty_q == (cnt_out_q == '0)))
    else $error("empty flag disagrees with count");

  a_err_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err |=> (count_q == $past(count_q)) && err_q)
    else $error("rejected transaction changed the count");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (count_q == $past(count_q) - cnt_t'(1)))
    else $error("pop did not remove one entry");
`endif

endmodule

// ===== rtl/smq_cell.sv =====
`timescale 1ns / 1ps

module smq_cell import smq_pkg::*; (
  input  logic  clk_i,
  input  cmd_t  cmd_i,
  input  logic  occ_i,
  input  link_t prev_i,
  input  val_t  next_val_i,
  output link_t link_o,
  output val_t  val_d_o
);

  val_t val_q, val_d;
  logic gt;

  // Empty cells act as +infinity; a new value goes above equal entries
  assign gt = !occ_i || (cmd_i.value <= val_q);

  always_comb begin
    val_d = val_q;
    if (cmd_i.push) begin
      if (prev_i.gt) begin
        val_d = prev_i.val;
      end else if (gt) begin
        val_d = cmd_i.value;
      end
    end else if (cmd_i.pop) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o  = '{val: val_q, gt: gt};
  assign val_d_o = val_d;

endmodule
